>>> rtl/core/tmhq_pkg.sv
package tmhq_pkg;

	localparam int unsigned CAPACITY = 128;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned ENTRY_W  = 8;

	localparam logic signed [KEY_W-1:0] EMPTY_KEY = {1'b0, {(KEY_W-1){1'b1}}};

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

>>> rtl/core/tmhq_cell.sv
module tmhq_cell (
	input  logic                                  clk,
	input  tmhq_pkg::cell_ctrl_t                  ctrl,
	input  logic                                  valid,
	input  logic signed [tmhq_pkg::KEY_W-1:0]     key_in,
	input  logic signed [tmhq_pkg::KEY_W-1:0]     prev_key,
	input  logic                                  prev_le,
	input  logic signed [tmhq_pkg::KEY_W-1:0]     next_key,
	output logic signed [tmhq_pkg::KEY_W-1:0]     key_q,
	output logic                                  le
);

	// the row is sorted ascending, so le is high on a prefix of cells
	assign le = valid && (key_q <= key_in);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!le) begin
				// first cell past the insertion point takes the new key, the rest shift up
				key_q <= prev_le ? key_in : prev_key;
			end
		end else if (ctrl.del) begin
			key_q <= next_key;
		end
	end

endmodule

>>> rtl/core/ternary_min_heap_queue_top.sv
// Priority queue of signed 32-bit keys, smallest key out first.
// Input channel (in_valid/in_ready): opcode selects insert (key_in) or
// delete-min. Output channel (out_valid/out_ready): one result per input
// transfer with key_out, status and entry_count (keys held afterwards).
// Keys live in a row of CAPACITY cells kept in ascending order; on an
// insert each cell past the insertion point takes key_in or its lower
// neighbor's key; a delete-min shifts the whole row toward cell 0.
// The registered result appears in the cycle after the input transfer.
// Throughput: one operation per cycle while out_ready holds, set by the
// single output register; in_ready is high while it is empty or taken.
// A full heap drops an insert and reports full status with key_in echoed.
// A delete-min on an empty heap reports empty status and key 2147483647.
// Reset clears the entry count and the output valid; the queue starts
// empty and cell contents need no clearing.
// When the receiver stalls, the result holds and in_ready drops until the
// result is transferred.
module ternary_min_heap_queue_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic signed [tmhq_pkg::KEY_W-1:0]     key_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [tmhq_pkg::KEY_W-1:0]     key_out,
	output logic [1:0]                            status,
	output logic [tmhq_pkg::ENTRY_W-1:0]          entry_count
);

	localparam int unsigned N = tmhq_pkg::CAPACITY;

	logic [tmhq_pkg::COUNT_W-1:0]          count_q;
	logic                                  out_valid_q;
	logic signed [tmhq_pkg::KEY_W-1:0]     key_out_q;
	tmhq_pkg::status_t                     status_q;

	logic signed [tmhq_pkg::KEY_W-1:0]     cell_key [N];
	logic [N-1:0]                          cell_le;
	logic [N-1:0]                          cell_valid;

	logic                                  xfer_in;
	logic                                  is_full;
	logic                                  is_empty;
	tmhq_pkg::cell_ctrl_t                  ctrl;

	assign in_ready = !out_valid_q || out_ready;
	assign xfer_in  = in_valid && in_ready;
	assign is_full  = (count_q == tmhq_pkg::COUNT_W'(N));
	assign is_empty = (count_q == '0);

	always_comb begin
		ctrl.ins = xfer_in && (opcode == tmhq_pkg::OP_INSERT) && !is_full;
		ctrl.del = xfer_in && (opcode == tmhq_pkg::OP_DELETE) && !is_empty;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign cell_valid[i] = (count_q > tmhq_pkg::COUNT_W'(i));

		if (i == 0) begin : g_first
			tmhq_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.valid    (cell_valid[i]),
				.key_in   (key_in),
				.prev_key (key_in),
				.prev_le  (1'b1),
				.next_key (cell_key[i+1]),
				.key_q    (cell_key[i]),
				.le       (cell_le[i])
			);
		end else if (i == N - 1) begin : g_last
			tmhq_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.valid    (cell_valid[i]),
				.key_in   (key_in),
				.prev_key (cell_key[i-1]),
				.prev_le  (cell_le[i-1]),
				.next_key (tmhq_pkg::EMPTY_KEY),
				.key_q    (cell_key[i]),
				.le       (cell_le[i])
			);
		end else begin : g_mid
			tmhq_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.valid    (cell_valid[i]),
				.key_in   (key_in),
				.prev_key (cell_key[i-1]),
				.prev_le  (cell_le[i-1]),
				.next_key (cell_key[i+1]),
				.key_q    (cell_key[i]),
				.le       (cell_le[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.del) begin
				count_q <= count_q - 1'b1;
			end
			if (xfer_in) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer_in) begin
			if (opcode == tmhq_pkg::OP_INSERT) begin
				key_out_q <= key_in;
				status_q  <= is_full ? tmhq_pkg::ST_FULL : tmhq_pkg::ST_OK;
			end else begin
				key_out_q <= is_empty ? tmhq_pkg::EMPTY_KEY : cell_key[0];
				status_q  <= is_empty ? tmhq_pkg::ST_EMPTY : tmhq_pkg::ST_OK;
			end
		end
	end

	// count_q only moves on an input transfer, which also reloads the result
	assign out_valid   = out_valid_q;
	assign key_out     = key_out_q;
	assign status      = status_q;
	assign entry_count = tmhq_pkg::ENTRY_W'(count_q);

endmodule

>>> rtl/core/tmhq_checker.sv
module tmhq_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  opcode,
	input logic signed [tmhq_pkg::KEY_W-1:0]     key_in,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [tmhq_pkg::KEY_W-1:0]     key_out,
	input logic [1:0]                            status,
	input logic [tmhq_pkg::ENTRY_W-1:0]          entry_count
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_out) && $stable(status))
		else $error("result changed while stalled");

	// insert result echoes the key in the cycle after the transfer
	a_ins_echo: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == tmhq_pkg::OP_INSERT)
		|=> out_valid && (key_out == $past(key_in)))
		else $error("insert result does not echo key");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == tmhq_pkg::ST_EMPTY)
		|-> (entry_count == '0) && (key_out == tmhq_pkg::EMPTY_KEY))
		else $error("empty status with bad count or key");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == tmhq_pkg::ST_FULL)
		|-> entry_count == tmhq_pkg::ENTRY_W'(tmhq_pkg::CAPACITY))
		else $error("full status with count below capacity");

endmodule

bind ternary_min_heap_queue_top tmhq_checker u_tmhq_checker (.*);
